[sv/cstb_pkg.sv]
// Shared types and character codes for the C comment and literal blanker.
// No dependencies; every other file imports this package.
package cstb_pkg;

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  // Most output bytes one input byte can release.
  localparam int unsigned GRP_MAX = 3;

  typedef enum logic [3:0] {
    ST_NORMAL   = 4'd0,
    ST_SLASH    = 4'd1,
    ST_LINE     = 4'd2,
    ST_BLOCK    = 4'd3,
    ST_STAR     = 4'd4,
    ST_DIR      = 4'd5,
    ST_DIR_BS   = 4'd6,
    ST_DIR_BSCR = 4'd7,
    ST_LIT      = 4'd8,
    ST_LIT_BS   = 4'd9
  } scan_state_t;

  typedef struct packed {
    scan_state_t state;
    logic        quote_single;
    logic        line_start;
  } scan_t;

  localparam scan_t SCAN_RESET = '{state: ST_NORMAL, quote_single: 1'b0, line_start: 1'b1};

  // Output bytes released by one input byte; fin marks the last byte as final.
  typedef struct packed {
    logic [GRP_MAX-1:0][7:0] bytes;
    logic [1:0]              cnt;
    logic                    fin;
  } grp_t;

endpackage

[sv/cstb_scanner.sv]
// Scanner state and the single-pass step logic for one input byte.
// Depends on cstb_pkg.
module cstb_scanner
  import cstb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  input  logic       advance_i,
  output grp_t       grp_o,
  output scan_t      scan_o
);

  typedef struct packed {
    scan_t sc;
    grp_t  grp;
  } step_t;

  scan_t scan_r;
  scan_t scan_nxt;
  step_t st;

  function automatic step_t emit(step_t s, logic [7:0] b);
    step_t r;
    r = s;
    if (s.grp.cnt != 2'd3) begin
      r.grp.bytes[s.grp.cnt] = b;
      r.grp.cnt              = s.grp.cnt + 2'd1;
    end
    return r;
  endfunction

  function automatic step_t normal_byte(step_t s, logic [7:0] c);
    step_t r;
    r = s;
    if (c == CH_SLASH) begin
      r.sc.state = ST_SLASH;
    end else if (c == CH_HASH && s.sc.line_start) begin
      r.sc.state = ST_DIR;
      r = emit(r, CH_SPACE);
    end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
      r.sc.quote_single = (c == CH_SQUOTE);
      r.sc.state        = ST_LIT;
      r = emit(r, CH_SPACE);
    end else begin
      if (c == CH_LF) begin
        r.sc.line_start = 1'b1;
      end else if (c != CH_SPACE && c != CH_TAB) begin
        r.sc.line_start = 1'b0;
      end
      r = emit(r, c);
    end
    return r;
  endfunction

  function automatic step_t dir_byte(step_t s, logic [7:0] c);
    step_t r;
    r = s;
    if (c == CH_BSLASH) begin
      r.sc.state = ST_DIR_BS;
    end else if (c == CH_LF) begin
      r.sc.state      = ST_NORMAL;
      r.sc.line_start = 1'b1;
      r = emit(r, CH_LF);
    end else begin
      r = emit(r, CH_SPACE);
    end
    return r;
  endfunction

  function automatic step_t block_byte(step_t s, logic [7:0] c);
    step_t r;
    r = s;
    if (c == CH_STAR) begin
      r.sc.state = ST_STAR;
    end else begin
      r = emit(r, (c == CH_LF) ? CH_LF : CH_SPACE);
    end
    return r;
  endfunction

  always_comb begin
    logic [7:0] q;
    st     = '0;
    st.sc  = scan_r;
    q      = scan_r.quote_single ? CH_SQUOTE : CH_DQUOTE;
    unique case (scan_r.state)
      ST_NORMAL: st = normal_byte(st, byte_i);
      ST_SLASH: begin
        if (byte_i == CH_SLASH || byte_i == CH_STAR) begin
          st = emit(st, CH_SPACE);
          st = emit(st, CH_SPACE);
          st.sc.state = (byte_i == CH_SLASH) ? ST_LINE : ST_BLOCK;
        end else begin
          st = emit(st, CH_SLASH);
          st.sc.line_start = 1'b0;
          st.sc.state      = ST_NORMAL;
          st = normal_byte(st, byte_i);
        end
      end
      ST_LINE: begin
        if (byte_i == CH_LF) begin
          st.sc.state = ST_NORMAL;
          st = normal_byte(st, byte_i);
        end else begin
          st = emit(st, CH_SPACE);
        end
      end
      ST_BLOCK: st = block_byte(st, byte_i);
      ST_STAR: begin
        if (byte_i == CH_SLASH) begin
          st = emit(st, CH_SPACE);
          st = emit(st, CH_SPACE);
          st.sc.state      = ST_NORMAL;
          st.sc.line_start = 1'b0;
        end else begin
          st = emit(st, CH_SPACE);
          st.sc.state = ST_BLOCK;
          st = block_byte(st, byte_i);
        end
      end
      ST_DIR: st = dir_byte(st, byte_i);
      ST_DIR_BS: begin
        if (byte_i == CH_LF) begin
          st = emit(st, CH_SPACE);
          st = emit(st, CH_LF);
          st.sc.state = ST_DIR;
        end else if (byte_i == CH_CR) begin
          st.sc.state = ST_DIR_BSCR;
        end else begin
          st = emit(st, CH_SPACE);
          st.sc.state = ST_DIR;
          st = dir_byte(st, byte_i);
        end
      end
      ST_DIR_BSCR: begin
        if (byte_i == CH_LF) begin
          st = emit(st, CH_SPACE);
          st = emit(st, CH_CR);
          st = emit(st, CH_LF);
          st.sc.state = ST_DIR;
        end else begin
          st = emit(st, CH_SPACE);
          st = emit(st, CH_SPACE);
          st.sc.state = ST_DIR;
          st = dir_byte(st, byte_i);
        end
      end
      ST_LIT: begin
        if (byte_i == CH_BSLASH) begin
          st.sc.state = ST_LIT_BS;
        end else if (byte_i == q) begin
          st = emit(st, CH_SPACE);
          st.sc.state      = ST_NORMAL;
          st.sc.line_start = 1'b0;
        end else begin
          st = emit(st, (byte_i == CH_LF) ? CH_LF : CH_SPACE);
        end
      end
      ST_LIT_BS: begin
        st = emit(st, CH_SPACE);
        st = emit(st, CH_SPACE);
        st.sc.state = ST_LIT;
      end
      default: begin
        st.sc.state = ST_NORMAL;
        st = normal_byte(st, byte_i);
      end
    endcase

    // flush whatever is held back, mark the final byte, start a fresh text
    if (last_i) begin
      unique case (st.sc.state)
        ST_SLASH:    st = emit(st, CH_SLASH);
        ST_STAR:     st = emit(st, CH_SPACE);
        ST_DIR_BS:   st = emit(st, CH_SPACE);
        ST_DIR_BSCR: begin
          st = emit(st, CH_SPACE);
          st = emit(st, CH_SPACE);
        end
        ST_LIT_BS:   st = emit(st, CH_SPACE);
        default:     st = st;
      endcase
      st.grp.fin = 1'b1;
      st.sc      = SCAN_RESET;
    end
  end

  assign scan_nxt = st.sc;
  assign grp_o    = st.grp;
  assign scan_o   = scan_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= SCAN_RESET;
    end else if (advance_i) begin
      scan_r <= scan_nxt;
    end
  end

endmodule

[sv/cstb_out_buf.sv]
// Result register: holds the bytes released by one input byte and sends
// them out one per transfer. Depends on cstb_pkg.
module cstb_out_buf
  import cstb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load_i,
  input  grp_t       grp_i,
  output logic       can_load_o,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_out_byte,
  output logic       out_final_flag
);

  grp_t       grp_r;
  logic       vld_r;
  logic [1:0] idx_r;
  logic       at_last;
  logic       take;

  assign at_last        = (idx_r == grp_r.cnt - 2'd1);
  assign take           = vld_r && out_ready;
  assign can_load_o     = !vld_r || (take && at_last);
  assign out_valid      = vld_r;
  assign out_out_byte   = grp_r.bytes[idx_r];
  assign out_final_flag = grp_r.fin && at_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= 2'd0;
    end else if (load_i) begin
      vld_r <= 1'b1;
      idx_r <= 2'd0;
    end else if (take && at_last) begin
      vld_r <= 1'b0;
    end else if (take) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      grp_r <= grp_i;
    end
  end

endmodule

[sv/c_comment_string_blanker.sv]
// C comment and literal blanker: takes C source one byte per transfer and
// returns text of the same length, with line and block comments, string and
// character literals, and preprocessor directives that open a line blanked to
// spaces (newlines kept; backslash-newline continuations kept in directives).
// An input byte passes through an input register, then one pass of scanner
// logic, into a result register that holds up to three bytes. A byte whose
// meaning hangs on the next one ('/', a '*' in a block comment, a backslash)
// releases nothing and is flushed later, so a byte may release zero to three
// output bytes. A new byte is taken every cycle while each releases at most
// one byte and out_ready is high; a byte that releases more stalls the input
// side while the result register drains, one output transfer per cycle while
// out_ready is high. The output is exactly as long as the input. An input byte
// reaches the output through the input register and the result register.
// The final byte flushes any held byte, sets out_final_flag on the last output
// byte and returns the scanner to its reset state, so a new text may follow
// at once.
module c_comment_string_blanker
  import cstb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_text_byte,
  input  logic       in_end_of_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_out_byte,
  output logic       out_final_flag
);

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  logic       can_load;
  logic       advance;
  logic       load;
  grp_t       grp;
  scan_t      scan;

  // advance the held byte once the result register can take its bytes
  assign advance  = s1_valid_r && can_load;
  // load nothing: items that release no byte update state and vanish
  assign load     = advance && (grp.cnt != 2'd0);
  assign in_ready = !s1_valid_r || can_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_text_byte;
      s1_last_r <= in_end_of_text;
    end
  end

  cstb_scanner u_scanner (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_i    (s1_byte_r),
    .last_i    (s1_last_r),
    .advance_i (advance),
    .grp_o     (grp),
    .scan_o    (scan)
  );

  cstb_out_buf u_out_buf (
    .clk            (clk),
    .rst_n          (rst_n),
    .load_i         (load),
    .grp_i          (grp),
    .can_load_o     (can_load),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_out_byte   (out_out_byte),
    .out_final_flag (out_final_flag)
  );

  // A final byte always flushes at least one output byte.
  a_last_gives_output: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_last_r) |=> out_valid)
    else $error("final byte released no output");

  // The scanner is back in its reset state after the final byte.
  a_last_resets_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_last_r) |=>
      (scan.state == ST_NORMAL && scan.line_start && !scan.quote_single))
    else $error("scanner not reset after final byte");

  // A transfer in always lands in the input register.
  a_accept_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> s1_valid_r)
    else $error("accepted byte lost");

endmodule

[verif/testbench.sv]
// Self-checking bench for c_comment_string_blanker: C-like texts in, blanked text out.
// Holds its own scanner model and checks every output transfer against it.
// Depends on cstb_pkg and the block's RTL only.
`timescale 1ns / 1ps

module testbench
  import cstb_pkg::*;
();

  // Output byte paired with its final flag, as the block should present it.
  typedef struct packed {
    logic [7:0] text;
    logic       fin;
  } blank_byte_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_text_byte = 8'h20;
  logic       in_end_of_text = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_out_byte;
  logic       out_final_flag;

  // Idle percentages for each side and a long receiver hold-off in cycles.
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned rx_hold_left = 0;

  int unsigned mismatch_count = 0;
  int unsigned chars_sent = 0;

  // Scanner state of the model, kept apart from the block's.
  scan_state_t scan_st = ST_NORMAL;
  logic        quote_single = 1'b0;
  logic        at_line_start = 1'b1;
  logic [7:0]  released[$];
  blank_byte_t blanked_text[$];

  c_comment_string_blanker DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_text_byte   (in_text_byte),
    .in_end_of_text (in_end_of_text),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_out_byte   (out_out_byte),
    .out_final_flag (out_final_flag)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Generous fixed limit: far beyond the slowest correct run.
  initial begin
    #400000;
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Model of the scanner
  // ---------------------------------------------------------------------------

  // Plain text: a slash is held, a line-opening hash starts a directive, a quote
  // opens a literal, anything else passes and updates the line-start flag.
  function automatic void scan_plain(logic [7:0] c);
    if (c == CH_SLASH) begin
      scan_st = ST_SLASH;
    end else if (c == CH_HASH && at_line_start) begin
      scan_st = ST_DIR;
      released.push_back(CH_SPACE);
    end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
      quote_single = (c == CH_SQUOTE);
      scan_st = ST_LIT;
      released.push_back(CH_SPACE);
    end else begin
      if (c == CH_LF)
        at_line_start = 1'b1;
      else if (c != CH_SPACE && c != CH_TAB)
        at_line_start = 1'b0;
      released.push_back(c);
    end
  endfunction

  // Directive body: hold a backslash, close on LF, blank the rest.
  function automatic void scan_directive(logic [7:0] c);
    if (c == CH_BSLASH) begin
      scan_st = ST_DIR_BS;
    end else if (c == CH_LF) begin
      scan_st = ST_NORMAL;
      at_line_start = 1'b1;
      released.push_back(CH_LF);
    end else begin
      released.push_back(CH_SPACE);
    end
  endfunction

  // Block comment body: hold a star, keep newlines, blank the rest.
  function automatic void scan_block(logic [7:0] c);
    if (c == CH_STAR)
      scan_st = ST_STAR;
    else
      released.push_back((c == CH_LF) ? CH_LF : CH_SPACE);
  endfunction

  // Advance the model by one accepted byte and queue the bytes it releases.
  function automatic void predict_blanked(logic [7:0] c, logic last);
    logic [7:0]  closing;
    blank_byte_t entry;
    released.delete();
    case (scan_st)
      ST_NORMAL: scan_plain(c);
      ST_SLASH: begin
        if (c == CH_SLASH) begin
          released.push_back(CH_SPACE);
          released.push_back(CH_SPACE);
          scan_st = ST_LINE;
        end else if (c == CH_STAR) begin
          released.push_back(CH_SPACE);
          released.push_back(CH_SPACE);
          scan_st = ST_BLOCK;
        end else begin
          released.push_back(CH_SLASH);
          at_line_start = 1'b0;
          scan_st = ST_NORMAL;
          scan_plain(c);
        end
      end
      ST_LINE: begin
        if (c == CH_LF) begin
          scan_st = ST_NORMAL;
          scan_plain(c);
        end else begin
          released.push_back(CH_SPACE);
        end
      end
      ST_BLOCK: scan_block(c);
      ST_STAR: begin
        if (c == CH_SLASH) begin
          released.push_back(CH_SPACE);
          released.push_back(CH_SPACE);
          scan_st = ST_NORMAL;
          at_line_start = 1'b0;
        end else begin
          released.push_back(CH_SPACE);
          scan_st = ST_BLOCK;
          scan_block(c);
        end
      end
      ST_DIR: scan_directive(c);
      ST_DIR_BS: begin
        if (c == CH_LF) begin
          released.push_back(CH_SPACE);
          released.push_back(CH_LF);
          scan_st = ST_DIR;
        end else if (c == CH_CR) begin
          scan_st = ST_DIR_BSCR;
        end else begin
          released.push_back(CH_SPACE);
          scan_st = ST_DIR;
          scan_directive(c);
        end
      end
      ST_DIR_BSCR: begin
        if (c == CH_LF) begin
          released.push_back(CH_SPACE);
          released.push_back(CH_CR);
          released.push_back(CH_LF);
          scan_st = ST_DIR;
        end else begin
          released.push_back(CH_SPACE);
          released.push_back(CH_SPACE);
          scan_st = ST_DIR;
          scan_directive(c);
        end
      end
      ST_LIT: begin
        closing = quote_single ? CH_SQUOTE : CH_DQUOTE;
        if (c == CH_BSLASH) begin
          scan_st = ST_LIT_BS;
        end else if (c == closing) begin
          released.push_back(CH_SPACE);
          scan_st = ST_NORMAL;
          at_line_start = 1'b0;
        end else begin
          released.push_back((c == CH_LF) ? CH_LF : CH_SPACE);
        end
      end
      ST_LIT_BS: begin
        released.push_back(CH_SPACE);
        released.push_back(CH_SPACE);
        scan_st = ST_LIT;
      end
      default: begin
        scan_st = ST_NORMAL;
        scan_plain(c);
      end
    endcase

    // Flush whatever is still held on the last byte, then start afresh.
    if (last) begin
      case (scan_st)
        ST_SLASH:    released.push_back(CH_SLASH);
        ST_STAR:     released.push_back(CH_SPACE);
        ST_DIR_BS:   released.push_back(CH_SPACE);
        ST_DIR_BSCR: begin
          released.push_back(CH_SPACE);
          released.push_back(CH_SPACE);
        end
        ST_LIT_BS:   released.push_back(CH_SPACE);
        default: ;
      endcase
      scan_st = ST_NORMAL;
      quote_single = 1'b0;
      at_line_start = 1'b1;
    end

    foreach (released[i]) begin
      entry.text = released[i];
      entry.fin = last && (i == released.size() - 1);
      blanked_text.push_back(entry);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t mismatch: %s got %02h expected %02h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Compare each output transfer with the oldest outstanding byte.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (blanked_text.size() == 0) begin
        report_mismatch("unexpected output byte", out_out_byte, 8'h00);
      end else begin
        if (out_out_byte !== blanked_text[0].text)
          report_mismatch("out_byte", out_out_byte, blanked_text[0].text);
        if (out_final_flag !== blanked_text[0].fin)
          report_mismatch("final_flag", {7'd0, out_final_flag}, {7'd0, blanked_text[0].fin});
        void'(blanked_text.pop_front());
      end
    end
  end

  // Receiver: stall at random, or hold off entirely while a hold-off is counting down.
  always @(negedge clk) begin
    if (rx_hold_left > 0) begin
      out_ready = 1'b0;
      rx_hold_left--;
    end else begin
      out_ready = ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one byte; idle beforehand at random, then hold it until the transfer.
  task automatic send_char(input logic [7:0] c, input logic last);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_text_byte = c;
    in_end_of_text = last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_blanked(c, last);
    chars_sent++;
  endtask

  task automatic send_text(input logic [7:0] t[$]);
    foreach (t[i]) send_char(t[i], i == t.size() - 1);
  endtask

  task automatic send_string(input string s);
    logic [7:0] t[$];
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    send_text(t);
  endtask

  // Drop valid, wait for every outstanding byte, then let the pipeline settle.
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (blanked_text.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic [7:0] any_char();
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [7:0] word_char();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(8'h30, 8'h39));
    return 8'($urandom_range(8'h61, 8'h7A));
  endfunction

  // Append one C-like fragment with random content; a few are noise or left open.
  task automatic add_fragment(ref logic [7:0] t[$]);
    int         n;
    logic [7:0] q;
    n = $urandom_range(1, 6);
    case ($urandom_range(0, 11))
      0: repeat (n) t.push_back(word_char());
      1: begin
        if ($urandom_range(0, 1)) t.push_back($urandom_range(0, 1) ? CH_TAB : CH_SPACE);
        t.push_back(CH_HASH);
        repeat (n) begin
          case ($urandom_range(0, 7))
            0: begin t.push_back(CH_BSLASH); t.push_back(CH_LF); end
            1: begin t.push_back(CH_BSLASH); t.push_back(CH_CR); t.push_back(CH_LF); end
            2: begin t.push_back(CH_BSLASH); t.push_back(CH_CR); t.push_back(word_char()); end
            3: begin t.push_back(CH_BSLASH); t.push_back(any_char()); end
            default: t.push_back(word_char());
          endcase
        end
        t.push_back(CH_LF);
      end
      2: begin
        t.push_back(CH_SLASH);
        t.push_back(CH_SLASH);
        repeat (n) begin
          q = any_char();
          t.push_back((q == CH_LF) ? CH_SPACE : q);
        end
        t.push_back(CH_LF);
      end
      3: begin
        t.push_back(CH_SLASH);
        t.push_back(CH_STAR);
        repeat (n) begin
          case ($urandom_range(0, 4))
            0: t.push_back(CH_STAR);
            1: t.push_back(CH_SLASH);
            2: t.push_back(CH_LF);
            default: t.push_back(any_char());
          endcase
        end
        t.push_back(CH_STAR);
        t.push_back(CH_SLASH);
      end
      4, 5: begin
        q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
        t.push_back(q);
        repeat (n) begin
          case ($urandom_range(0, 5))
            0: begin t.push_back(CH_BSLASH); t.push_back(any_char()); end
            1: t.push_back(CH_LF);
            2: t.push_back((q == CH_SQUOTE) ? CH_DQUOTE : CH_SQUOTE);
            default: t.push_back(word_char());
          endcase
        end
        t.push_back(q);
      end
      6: begin
        t.push_back(word_char());
        t.push_back($urandom_range(0, 1) ? CH_SLASH : CH_STAR);
        if ($urandom_range(0, 1)) t.push_back(CH_SPACE);
        t.push_back(word_char());
      end
      7: begin
        if ($urandom_range(0, 1)) t.push_back(CH_CR);
        t.push_back(CH_LF);
      end
      8: repeat (n) t.push_back(any_char());
      9: begin
        t.push_back(word_char());
        t.push_back(CH_HASH);
      end
      10: begin
        // Left open: a comment, literal or directive that later text falls into, or a lone backslash.
        case ($urandom_range(0, 3))
          0: begin t.push_back(CH_SLASH); t.push_back(CH_STAR); end
          1: t.push_back(CH_DQUOTE);
          2: begin t.push_back(CH_LF); t.push_back(CH_HASH); t.push_back(CH_BSLASH); end
          default: t.push_back(CH_BSLASH);
        endcase
      end
      default: repeat (n) t.push_back($urandom_range(0, 1) ? CH_TAB : CH_SPACE);
    endcase
  endtask

  // Send random texts until about the given number of bytes have gone in.
  task automatic send_random_texts(input int unsigned count);
    logic [7:0]  t[$];
    int unsigned stop_at;
    stop_at = chars_sent + count;
    while (chars_sent < stop_at) begin
      t.delete();
      repeat ($urandom_range(1, 8)) add_fragment(t);
      send_text(t);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Held slash released by a high byte, a lone slash flushed at the end, a block
  // comment with a newline and a doubled star, and a star flushed at the end.
  task automatic test_comments();
    send_string("/\377");
    send_string("/");
    send_string("/*\n**/");
    send_string("/**");
    wait_drained();
  endtask

  // Continuations with LF and with CR LF, a backslash-CR before other text,
  // and the held backslash and backslash-CR flushed at the end of the text.
  task automatic test_directives();
    send_string("\t#\\\n\\\015\n\\\015c\\\015");
    send_string("#\\");
    wait_drained();
  endtask

  // Escaped newline inside a character literal, then a backslash left held
  // inside a string at the end of the text.
  task automatic test_literals();
    send_string("'\\\n'\"\\");
    wait_drained();
  endtask

  task automatic test_random_text(input int unsigned tx_pct, input int unsigned rx_pct,
                                  input int unsigned count);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    send_random_texts(count);
    wait_drained();
  endtask

  // Hold the receiver off for a long stretch while the sender keeps offering,
  // so the result register fills and the block stalls its input.
  task automatic test_output_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    @(negedge clk);
    rx_hold_left = 300;
    send_random_texts(50);
    wait_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    tx_idle_pct = 32;
    rx_idle_pct = 46;
    test_comments();
    test_directives();
    test_literals();
    test_random_text(32, 46, 85);
    test_random_text(46, 32, 85);
    test_random_text(0, 0, 85);
    test_output_backpressure();

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[c_comment_string_blanker.f]
sv/cstb_pkg.sv
sv/cstb_scanner.sv
sv/cstb_out_buf.sv
sv/c_comment_string_blanker.sv
verif/testbench.sv
